[hw/rtl/tts_pkg.sv]
// Shared types and constants for the tick task scheduler table.
// Depends on nothing; every other file in hw/rtl imports it.
`timescale 1ns / 1ps

package tts_pkg;

    // Table size; slot numbers are three bits wide, so at most eight slots are live.
    localparam int SLOTS   = 8;
    localparam int TABLE_N = (SLOTS > 8) ? 8 : SLOTS;
    localparam int IDX_W   = (TABLE_N > 1) ? $clog2(TABLE_N) : 1;

    localparam int CMD_W    = 2;
    localparam int RUNS_W   = 16;
    localparam int PERIOD_W = 15;
    localparam int KIND_W   = 3;
    localparam int SLOT_W   = 3;

    localparam logic signed [RUNS_W-1:0] RUNS_FOREVER = -16'sd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_REMOVE = 2'd2
    } cmd_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_QUIET   = 3'd0,
        KIND_FIRED   = 3'd1,
        KIND_EXPIRED = 3'd2,
        KIND_ADDED   = 3'd3,
        KIND_FULL    = 3'd4,
        KIND_REMOVED = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SCAN  = 2'd1,
        ST_FLUSH = 2'd2
    } state_t;

    // Outcome of visiting one occupied slot on a tick.
    typedef struct packed {
        logic                       fire;
        logic                       expire;
        logic [PERIOD_W-1:0]        count;
        logic signed [RUNS_W-1:0]   runs;
    } slot_upd_t;

endpackage

[hw/rtl/tick_task_scheduler_table_top.sv]
// Top level of the tick task scheduler table: slot store, scan sequencer, result register.
// Depends on tts_pkg and tts_slot_alu.
`timescale 1ns / 1ps

// Channel   Direction  Transfer when           Payload
// command   in         cmd_valid & !cmd_stall  cmd, run_count, period_ticks, slot_id
// result    out        res_valid & !res_stall  kind, slot, last
//
// An add, a remove or an unused command gives one result.
// A tick is accepted, then visits the slots one per cycle through the shared slot
// update unit while the scan is not held, and then releases the final result.
// Reset clears the occupancy bits and the sequencer; the other slot fields are
// written by an add before they are ever read.
// A stall on the result channel holds the scan whenever a second event is found
// while the result register is still full, and holds off new commands.

module tick_task_scheduler_table_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    output logic                                cmd_stall,
    input  logic [tts_pkg::CMD_W-1:0]           cmd,
    input  logic signed [tts_pkg::RUNS_W-1:0]   run_count,
    input  logic [tts_pkg::PERIOD_W-1:0]        period_ticks,
    input  logic [tts_pkg::SLOT_W-1:0]          slot_id,
    output logic                                res_valid,
    input  logic                                res_stall,
    output logic [tts_pkg::KIND_W-1:0]          kind,
    output logic [tts_pkg::SLOT_W-1:0]          slot,
    output logic                                last
);
    import tts_pkg::*;

    // Sequencer and scan position.
    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;

    // Slot table. Occupancy is reset; the payload fields are not.
    logic [TABLE_N-1:0]         used_reg, used_next;
    logic signed [RUNS_W-1:0]   runs_reg   [TABLE_N];
    logic signed [RUNS_W-1:0]   runs_next  [TABLE_N];
    logic [PERIOD_W-1:0]        period_reg [TABLE_N];
    logic [PERIOD_W-1:0]        period_next[TABLE_N];
    logic [PERIOD_W-1:0]        count_reg  [TABLE_N];
    logic [PERIOD_W-1:0]        count_next [TABLE_N];

    // An event found during the scan is held back here until we know whether it
    // is the last one, so that its last flag can be set correctly.
    logic               pend_valid_reg, pend_valid_next;
    kind_t              pend_kind_reg, pend_kind_next;
    logic [SLOT_W-1:0]  pend_slot_reg, pend_slot_next;

    // Result register.
    logic               res_valid_reg, res_valid_next;
    kind_t              kind_reg, kind_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic               last_reg, last_next;

    logic               out_free;
    logic               any_free;
    logic [IDX_W-1:0]   free_idx;
    logic               event_found;
    slot_upd_t          upd;

    // One update unit serves every slot, one slot per cycle while the scan is not held.
    tts_slot_alu u_alu (
        .runs   (runs_reg[idx_reg]),
        .count  (count_reg[idx_reg]),
        .period (period_reg[idx_reg]),
        .upd    (upd)
    );

    // Lowest free slot, for an add.
    always_comb
    begin
        any_free = 1'b0;
        free_idx = '0;
        for (int i = TABLE_N - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                any_free = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        used_next       = used_reg;
        runs_next       = runs_reg;
        period_next     = period_reg;
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_slot_next  = pend_slot_reg;
        res_valid_next  = res_valid_reg;
        kind_next       = kind_reg;
        slot_next       = slot_reg;
        last_next       = last_reg;

        // The result register can take a new result if it is empty or is being
        // emptied by a transfer at this edge.
        out_free = !res_valid_reg || !res_stall;
        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        cmd_stall   = !((state_reg == ST_IDLE) && out_free);
        event_found = used_reg[idx_reg] && (upd.fire || upd.expire);

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    res_valid_next = 1'b1;
                    last_next      = 1'b1;
                    kind_next      = KIND_QUIET;
                    slot_next      = '0;
                    case (cmd)
                        CMD_TICK:
                        begin
                            res_valid_next  = res_valid_reg && res_stall;
                            state_next      = ST_SCAN;
                            idx_next        = '0;
                            pend_valid_next = 1'b0;
                        end
                        CMD_ADD:
                        begin
                            if (any_free)
                            begin
                                used_next[free_idx]   = 1'b1;
                                runs_next[free_idx]   = run_count;
                                period_next[free_idx] = period_ticks;
                                count_next[free_idx]  = '0;
                                kind_next             = KIND_ADDED;
                                slot_next             = SLOT_W'(free_idx);
                            end
                            else
                            begin
                                kind_next = KIND_FULL;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (32'(slot_id) < TABLE_N)
                            begin
                                used_next[slot_id[IDX_W-1:0]] = 1'b0;
                            end
                            kind_next = KIND_REMOVED;
                            slot_next = slot_id;
                        end
                        default:
                        begin
                            kind_next = KIND_QUIET;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // Hold the slot when a held event must move out but cannot.
                if (!(event_found && pend_valid_reg && !out_free))
                begin
                    if (used_reg[idx_reg])
                    begin
                        if (upd.expire)
                        begin
                            used_next[idx_reg] = 1'b0;
                        end
                        else
                        begin
                            count_next[idx_reg] = upd.count;
                            runs_next[idx_reg]  = upd.runs;
                        end
                    end
                    if (event_found)
                    begin
                        if (pend_valid_reg)
                        begin
                            res_valid_next = 1'b1;
                            kind_next      = pend_kind_reg;
                            slot_next      = pend_slot_reg;
                            last_next      = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_kind_next  = upd.expire ? KIND_EXPIRED : KIND_FIRED;
                        pend_slot_next  = SLOT_W'(idx_reg);
                    end
                    if (idx_reg == IDX_W'(TABLE_N - 1))
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            ST_FLUSH:
            begin
                if (out_free)
                begin
                    res_valid_next  = 1'b1;
                    last_next       = 1'b1;
                    pend_valid_next = 1'b0;
                    if (pend_valid_reg)
                    begin
                        kind_next = pend_kind_reg;
                        slot_next = pend_slot_reg;
                    end
                    else
                    begin
                        kind_next = KIND_QUIET;
                        slot_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            used_reg       <= '0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            used_reg       <= used_next;
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        runs_reg      <= runs_next;
        period_reg    <= period_next;
        count_reg     <= count_next;
        pend_kind_reg <= pend_kind_next;
        pend_slot_reg <= pend_slot_next;
        kind_reg      <= kind_next;
        slot_reg      <= slot_next;
        last_reg      <= last_next;
    end

    assign res_valid = res_valid_reg;
    assign kind      = kind_reg;
    assign slot      = slot_reg;
    assign last      = last_reg;

endmodule

[hw/rtl/tts_slot_alu.sv]
// Shared slot update unit: decides fire or expiry for one slot and its new counters.
// Depends on tts_pkg.
`timescale 1ns / 1ps

module tts_slot_alu (
    input  logic signed [tts_pkg::RUNS_W-1:0]   runs,
    input  logic [tts_pkg::PERIOD_W-1:0]        count,
    input  logic [tts_pkg::PERIOD_W-1:0]        period,
    output tts_pkg::slot_upd_t                  upd
);
    import tts_pkg::*;

    logic active;
    logic positive;

    always_comb
    begin
        positive   = (runs > 0);
        active     = positive || (runs == RUNS_FOREVER);
        upd.expire = !active;
        upd.fire   = active && (count == period);
        if (upd.fire)
        begin
            upd.count = '0;
        end
        else
        begin
            upd.count = count + 1'b1;
        end
        if (upd.fire && positive)
        begin
            upd.runs = runs - 16'sd1;
        end
        else
        begin
            upd.runs = runs;
        end
    end

endmodule

[hw/rtl/tts_checker.sv]
// Port-level checks for the tick task scheduler table, bound to its top level.
// Depends on tts_pkg and tick_task_scheduler_table_top.
`timescale 1ns / 1ps

module tts_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                res_valid,
    input  logic                                res_stall,
    input  logic [tts_pkg::KIND_W-1:0]          kind,
    input  logic [tts_pkg::SLOT_W-1:0]          slot,
    input  logic                                last
);
    import tts_pkg::*;

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result withdrawn while stalled");

    // Commands other than a tick give exactly one result, so it is always the last.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (kind == KIND_ADDED || kind == KIND_FULL || kind == KIND_REMOVED)
        |-> last)
        else $error("single result without last flag");

    // A quiet tick only ever appears on its own.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind == KIND_QUIET |-> last && slot == '0)
        else $error("quiet result malformed");

    // Table full carries slot zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind == KIND_FULL |-> slot == '0)
        else $error("table full result names a slot");

endmodule

bind tick_task_scheduler_table_top tts_checker u_tts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .kind      (kind),
    .slot      (slot),
    .last      (last)
);
